[rtl/pidf_pkg.sv]
// pidf_pkg: widths, register indexes and shared types of the positional PID core.
// No dependencies; every rtl file imports it.
package pidf_pkg;

  localparam int SAMPLE_W   = 16;               // target / measured width
  localparam int GAIN_W     = 16;               // signed gain width
  localparam int GAIN_FRAC  = 8;                // fraction bits of the gains
  localparam int RATIO_W    = 9;                // smoothing ratio width
  localparam int RATIO_FRAC = 8;                // fraction bits of the ratio
  localparam int DB_W       = 16;               // dead band width
  localparam int LIMIT_W    = 31;               // saturation bound width
  localparam int DRIVE_W    = 32;               // output width
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam int ERR_W   = SAMPLE_W + 1;        // raw and filtered error
  localparam int DIFF_W  = ERR_W + 1;           // error difference, lane operand
  localparam int PROD_W  = DIFF_W + GAIN_W;     // full lane product
  localparam int TERM_W  = PROD_W - GAIN_FRAC;  // product after the gain shift
  localparam int SUM_W   = ((TERM_W > DRIVE_W) ? TERM_W : DRIVE_W) + 2;

  // radix-4 Booth: one signed digit of the multiplier per cycle while run is set
  localparam int BOOTH_DIGITS = GAIN_W / 2;
  localparam int CNT_W        = $clog2(BOOTH_DIGITS);

  localparam int RATIO_ONE = 1 << RATIO_FRAC;   // unity weight, no filtering

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4,
    REG_DEAD_BAND      = 3'd5,
    REG_SMOOTHING      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [LIMIT_W-1:0]       output_limit;
    logic [DB_W-1:0]          dead_band;
    logic [RATIO_W-1:0]       ratio;            // already limited to RATIO_ONE
  } cfg_t;

  typedef struct packed {
    logic load;                                 // take new operands, clear product
    logic run;                                  // retire one multiplier digit
  } lane_ctrl_t;

endpackage

[rtl/pidf_cfg_regs.sv]
// pidf_cfg_regs: configuration register file of the PID core.
// Depends on pidf_pkg for register indexes and the cfg_t bundle.
module pidf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidf_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [pidf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pidf_pkg::cfg_t                     cfg
);
  import pidf_pkg::*;

  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;
  logic [LIMIT_W-1:0]       integral_limit;
  logic [LIMIT_W-1:0]       output_limit;
  logic [DB_W-1:0]          dead_band;
  logic [RATIO_W-1:0]       smoothing_ratio;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      integral_limit  <= '0;
      output_limit    <= '0;
      dead_band       <= '0;
      smoothing_ratio <= RATIO_W'(RATIO_ONE);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_P:         gain_p          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:         gain_i          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:         gain_d          <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit  <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   output_limit    <= cfg_data[LIMIT_W-1:0];
        REG_DEAD_BAND:      dead_band       <= cfg_data[DB_W-1:0];
        REG_SMOOTHING:      smoothing_ratio <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.gain_p         = gain_p;
    cfg.gain_i         = gain_i;
    cfg.gain_d         = gain_d;
    cfg.integral_limit = integral_limit;
    cfg.output_limit   = output_limit;
    cfg.dead_band      = dead_band;
    // weights above unity mean no filtering
    cfg.ratio = (smoothing_ratio > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE)
                                                        : smoothing_ratio;
  end

endmodule

[rtl/pidf_booth_lane.sv]
// pidf_booth_lane: digit-serial signed multiplier, one radix-4 Booth digit per cycle while ctrl.run is set.
// Depends on pidf_pkg for operand widths and the lane control struct.
module pidf_booth_lane (
  input  logic                                clk,
  input  pidf_pkg::lane_ctrl_t                ctrl,
  input  logic signed [pidf_pkg::DIFF_W-1:0]  mcand,
  input  logic signed [pidf_pkg::GAIN_W-1:0]  mplier,
  output logic signed [pidf_pkg::PROD_W-1:0]  product
);
  import pidf_pkg::*;

  logic signed [PROD_W-1:0] mc;       // multiplicand, moves up one digit a cycle while running
  logic [GAIN_W:0]          mp;       // multiplier with the Booth guard bit
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] pp;

  always_comb begin
    case (mp[2:0])
      3'b001, 3'b010: pp = mc;
      3'b011:         pp = mc <<< 1;
      3'b100:         pp = -(mc <<< 1);
      3'b101, 3'b110: pp = -mc;
      default:        pp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mc  <= PROD_W'(mcand);
      mp  <= {mplier, 1'b0};
      acc <= '0;
    end else if (ctrl.run) begin
      acc <= acc + pp;
      mc  <= mc <<< 2;
      mp  <= {{2{mp[GAIN_W]}}, mp[GAIN_W:2]};
    end
  end

  assign product = acc;

endmodule

[rtl/positional_pid_deadzone_lpf_core.sv]
// positional_pid_deadzone_lpf_core: positional PID with error dead band and low-pass filter.
// Depends on pidf_pkg, pidf_cfg_regs and pidf_booth_lane.
//
//  channel  signals                                    direction
//  cfg      cfg_valid cfg_ready cfg_index cfg_data     write into the register file
//  in       in_valid in_ready action target measured   one step or clear request
//  out      out_valid out_ready drive                  one result per request
//
// A control step runs from acceptance to the next acceptance through the dead band
// state, two 8-digit passes through the radix-4 Booth lanes (filter, then P/I/D
// in parallel) with a load state between them, and then accumulation, saturation
// and the return to idle. A clear goes straight to the output state.
// Reset clears the error history, the integrator and the registers (ratio to unity).
// A stalled output holds the finished drive; the next request waits behind it only
// when a new result is ready to be written.
module positional_pid_deadzone_lpf_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pidf_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [pidf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic signed [pidf_pkg::SAMPLE_W-1:0]  target,
  input  logic signed [pidf_pkg::SAMPLE_W-1:0]  measured,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pidf_pkg::DRIVE_W-1:0]   drive
);
  import pidf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_FILT, S_PREP, S_GAIN, S_INTEG, S_OUT
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          dig_cnt;
  logic signed [ERR_W-1:0]   raw;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [DRIVE_W-1:0] integ;
  logic signed [SUM_W-1:0]   pd;

  cfg_t                      cfg;
  lane_ctrl_t                ctrl0;
  lane_ctrl_t                ctrl12;
  logic signed [DIFF_W-1:0]  mcand0;
  logic signed [GAIN_W-1:0]  mplier0;
  logic signed [PROD_W-1:0]  prod0;
  logic signed [PROD_W-1:0]  prod1;
  logic signed [PROD_W-1:0]  prod2;

  logic [ERR_W-1:0]          mag;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  err_diff;
  logic signed [DIFF_W-1:0]  filt_step;
  logic signed [DIFF_W-1:0]  filt_wide;
  logic signed [ERR_W-1:0]   filt;
  logic signed [TERM_W-1:0]  term_p;
  logic signed [TERM_W-1:0]  term_i;
  logic signed [TERM_W-1:0]  term_d;
  logic signed [SUM_W-1:0]   pd_next;
  logic signed [DRIVE_W-1:0] integ_next;
  logic signed [DRIVE_W-1:0] drive_next;
  logic                      last_digit;

  function automatic logic signed [DRIVE_W-1:0] sat_sym(
    input logic signed [SUM_W-1:0] x,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [SUM_W-1:0] hi;
    hi = $signed(SUM_W'(lim));
    if (x > hi)
      return DRIVE_W'(hi);
    else if (x < -hi)
      return DRIVE_W'(-hi);
    else
      return DRIVE_W'(x);
  endfunction

  pidf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // dead band, then the filter operand e - prev
  always_comb begin
    mag      = raw[ERR_W-1] ? ERR_W'(-raw) : ERR_W'(raw);
    err      = (mag < ERR_W'(cfg.dead_band)) ? '0 : raw;
    err_diff = DIFF_W'(err) - DIFF_W'(prev_error);
  end

  // floor((e*r + prev*(1-r)) >> 8) equals prev + floor((e - prev)*r >> 8);
  // the shifted product is also the D operand filt - prev
  always_comb begin
    filt_step = prod0[RATIO_FRAC +: DIFF_W];
    filt_wide = DIFF_W'(prev_error) + filt_step;
    filt      = filt_wide[ERR_W-1:0];
  end

  always_comb begin
    ctrl0.load  = (state == S_ERR) || (state == S_PREP);
    ctrl0.run   = (state == S_FILT) || (state == S_GAIN);
    ctrl12.load = (state == S_PREP);
    ctrl12.run  = (state == S_GAIN);
    mcand0      = (state == S_ERR) ? err_diff : DIFF_W'(filt);
    mplier0     = (state == S_ERR) ? GAIN_W'(cfg.ratio) : cfg.gain_p;
  end

  // lane 0 runs the filter, then the P term; lanes 1 and 2 run I and D
  pidf_booth_lane u_lane_p (
    .clk     (clk),
    .ctrl    (ctrl0),
    .mcand   (mcand0),
    .mplier  (mplier0),
    .product (prod0)
  );

  pidf_booth_lane u_lane_i (
    .clk     (clk),
    .ctrl    (ctrl12),
    .mcand   (DIFF_W'(filt)),
    .mplier  (cfg.gain_i),
    .product (prod1)
  );

  pidf_booth_lane u_lane_d (
    .clk     (clk),
    .ctrl    (ctrl12),
    .mcand   (filt_step),
    .mplier  (cfg.gain_d),
    .product (prod2)
  );

  always_comb begin
    term_p     = prod0[PROD_W-1:GAIN_FRAC];
    term_i     = prod1[PROD_W-1:GAIN_FRAC];
    term_d     = prod2[PROD_W-1:GAIN_FRAC];
    pd_next    = SUM_W'(term_p) + SUM_W'(term_d);
    integ_next = sat_sym(SUM_W'(integ) + SUM_W'(term_i), cfg.integral_limit);
    drive_next = sat_sym(pd + SUM_W'(integ), cfg.output_limit);
    last_digit = (dig_cnt == CNT_W'(BOOTH_DIGITS - 1));
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dig_cnt    <= '0;
      out_valid  <= 1'b0;
      prev_error <= '0;
      integ      <= '0;
    end else begin
      // in S_OUT the state branch owns out_valid
      if (out_valid && out_ready && (state != S_OUT))
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (action) begin
              // clear history; the zero sums saturate to a zero drive
              prev_error <= '0;
              integ      <= '0;
              pd         <= '0;
              state      <= S_OUT;
            end else begin
              raw   <= ERR_W'(target) - ERR_W'(measured);
              state <= S_ERR;
            end
          end
        end
        S_ERR: begin
          dig_cnt <= '0;
          state   <= S_FILT;
        end
        S_FILT: begin
          dig_cnt <= last_digit ? '0 : dig_cnt + 1'b1;
          if (last_digit)
            state <= S_PREP;
        end
        S_PREP: begin
          prev_error <= filt;
          state      <= S_GAIN;
        end
        S_GAIN: begin
          dig_cnt <= last_digit ? '0 : dig_cnt + 1'b1;
          if (last_digit)
            state <= S_INTEG;
        end
        S_INTEG: begin
          integ <= integ_next;
          pd    <= pd_next;
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            drive     <= drive_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((drive <= $signed({1'b0, cfg.output_limit}))
                && (drive >= -$signed({1'b0, cfg.output_limit}))))
    else $error("drive outside the output limit");

  a_clear_history: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action) |=> ((prev_error == '0) && (integ == '0)))
    else $error("clear request left history behind");

  a_digit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (dig_cnt == '0))
    else $error("digit counter not at rest between requests");

endmodule

[test/positional_pid_deadzone_lpf_core_tb.sv]
// positional_pid_deadzone_lpf_core_tb: self-checking bench for the positional PID core.
// Drives steps and clears, predicts every drive value and compares it on the output channel.
// Depends on pidf_pkg and positional_pid_deadzone_lpf_core.
`timescale 1ns / 100ps

module positional_pid_deadzone_lpf_core_tb;
  import pidf_pkg::*;

  localparam int HOLD_LEN    = 300;   // long output hold for the back-pressure test
  localparam int IDLE_TAIL   = 25;    // idle wait after drain, longer than a step takes
  localparam int STALL_LIMIT = 3000;  // cycles without any handshake
  localparam int MAX_REPORTS = 20;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [REG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic                        action;
  logic signed [SAMPLE_W-1:0]  target;
  logic signed [SAMPLE_W-1:0]  measured;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [DRIVE_W-1:0]   drive;

  positional_pid_deadzone_lpf_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .target    (target),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

  // controller copy: registers and history
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [LIMIT_W-1:0]       integ_lim, drive_lim;
  logic [DB_W-1:0]          band;
  logic [RATIO_W-1:0]       ratio_q8;
  longint                   err_prev, integ_acc;

  logic signed [DRIVE_W-1:0] expected_drive[$];

  int errors      = 0;
  int n_requests  = 0;
  int n_clears    = 0;
  int n_results   = 0;
  int n_writes    = 0;
  int quiet_cycles = 0;
  int in_idle_pct  = 0;
  int out_stall_pct = 0;
  bit hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_sym(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:         kp = data[GAIN_W-1:0];
      REG_GAIN_I:         ki = data[GAIN_W-1:0];
      REG_GAIN_D:         kd = data[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: integ_lim = data[LIMIT_W-1:0];
      REG_OUTPUT_LIMIT:   drive_lim = data[LIMIT_W-1:0];
      REG_DEAD_BAND:      band = data[DB_W-1:0];
      REG_SMOOTHING:      ratio_q8 = data[RATIO_W-1:0];
      default: ;
    endcase
  endfunction

  // one controller step or clear; updates the error history and the integrator
  function automatic logic signed [DRIVE_W-1:0] predict_drive(logic act,
      logic signed [SAMPLE_W-1:0] tgt, logic signed [SAMPLE_W-1:0] meas);
    longint raw, mag, err, r, filt, d_term, p_term, sum;
    if (act) begin
      err_prev  = 0;
      integ_acc = 0;
      return '0;
    end
    raw  = longint'(tgt) - longint'(meas);
    mag  = (raw < 0) ? -raw : raw;
    err  = (mag < longint'(band)) ? 0 : raw;
    r    = (ratio_q8 > RATIO_ONE) ? RATIO_ONE : longint'(ratio_q8);
    filt = (err * r + err_prev * (RATIO_ONE - r)) >>> RATIO_FRAC;
    d_term = ((filt - err_prev) * longint'(kd)) >>> GAIN_FRAC;
    p_term = (filt * longint'(kp)) >>> GAIN_FRAC;
    integ_acc = clamp_sym(integ_acc + ((filt * longint'(ki)) >>> GAIN_FRAC),
                          longint'(integ_lim));
    sum = clamp_sym(d_term + p_term + integ_acc, longint'(drive_lim));
    err_prev = filt;
    return sum[DRIVE_W-1:0];
  endfunction

  // random bits above the field, so the block must ignore them
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] val, int width);
    logic [CFG_DATA_W-1:0] mask;
    mask = (32'h1 << width) - 32'h1;
    return ($urandom & ~mask) | (val & mask);
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_request(input logic act, input logic signed [SAMPLE_W-1:0] tgt,
                              input logic signed [SAMPLE_W-1:0] meas);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    target   = tgt;
    measured = meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_drive.push_back(predict_drive(act, tgt, meas));
    n_requests++;
    if (act) n_clears++;
  endtask

  // drop valid, let every result come back, then let the core settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic step(input logic signed [SAMPLE_W-1:0] tgt,
                      input logic signed [SAMPLE_W-1:0] meas);
    send_request(1'b0, tgt, meas);
  endtask

  task automatic clear_history();
    send_request(1'b1, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic test_reset_defaults();
    // all gains zero and no filtering after reset
    step(16'sd1000, -16'sd1000);
    step(-16'sd5, 16'sd7);
    drain();
  endtask

  task automatic test_directed_cases();
    write_reg(REG_GAIN_P, with_junk(32'd256, GAIN_W));
    write_reg(REG_GAIN_I, 32'h7FFF);
    write_reg(REG_GAIN_D, 32'h8000);
    write_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_OUTPUT_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_DEAD_BAND, 32'd0);
    write_reg(REG_SMOOTHING, 32'd256);
    write_reg(REG_UNUSED, $urandom);
    step(16'sh7FFF, 16'sh8000);
    step(16'sh8000, 16'sh7FFF);
    step(16'sd0, 16'sd0);
    clear_history();
    step(16'sd5, 16'sd0);
    drain();

    // dead band edges: just inside, on the edge, both signs
    write_reg(REG_DEAD_BAND, with_junk(32'd100, DB_W));
    step(16'sd99, 16'sd0);
    step(16'sd100, 16'sd0);
    step(-16'sd100, 16'sd0);
    step(16'sd0, 16'sd99);
    drain();
    write_reg(REG_DEAD_BAND, 32'hFFFF);
    step(16'sh7FFE, 16'sh8000);
    step(16'sh7FFF, 16'sh8000);
    drain();

    // filter fully closed, then a ratio above unity
    write_reg(REG_DEAD_BAND, 32'd0);
    write_reg(REG_SMOOTHING, 32'd0);
    step(16'sd1000, 16'sd0);
    drain();
    write_reg(REG_SMOOTHING, with_junk(32'd511, RATIO_W));
    step(16'sd1000, 16'sd0);
    drain();

    // zero limits clamp everything
    write_reg(REG_INTEGRAL_LIMIT, 32'd0);
    write_reg(REG_OUTPUT_LIMIT, 32'd0);
    step(16'sh7FFF, 16'sh8000);
    clear_history();
    drain();

    // opposite gain extremes
    write_reg(REG_GAIN_P, 32'h8000);
    write_reg(REG_GAIN_I, 32'h8000);
    write_reg(REG_GAIN_D, 32'h7FFF);
    write_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_OUTPUT_LIMIT, 32'hFFFF_FFFF);
    step(16'sh7FFF, 16'sh8000);
    step(16'sh8000, 16'sh7FFF);
    drain();
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] v;
    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(0, 3))
        0:       v = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
        1:       v = 32'($urandom_range(0, 1023)) - 32'd512;
        default: v = $urandom;
      endcase
      write_reg(g == 0 ? REG_GAIN_P : (g == 1 ? REG_GAIN_I : REG_GAIN_D), with_junk(v, GAIN_W));
    end
    for (int g = 0; g < 2; g++) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h7FFF_FFFF;
        1:       v = $urandom_range(0, 100000);
        2:       v = $urandom_range(0, 1000);
        default: v = $urandom;
      endcase
      write_reg(g == 0 ? REG_INTEGRAL_LIMIT : REG_OUTPUT_LIMIT, with_junk(v, LIMIT_W));
    end
    v = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom;
    write_reg(REG_DEAD_BAND, with_junk(v, DB_W));
    v = $urandom_range(0, 2) ? $urandom_range(0, 511) : RATIO_ONE;
    write_reg(REG_SMOOTHING, with_junk(v, RATIO_W));
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    logic signed [SAMPLE_W-1:0] tgt, meas;
    int off;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    randomize_config();
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
        randomize_config();
      end
      if ($urandom_range(0, 99) < 6) begin
        clear_history();
      end else begin
        tgt = SAMPLE_W'($urandom);
        // half of the steps stay near the dead band edge
        if ($urandom_range(0, 1)) begin
          meas = SAMPLE_W'($urandom);
        end else begin
          off  = int'($urandom_range(0, 800)) - 400;
          meas = tgt + SAMPLE_W'(off);
        end
        step(tgt, meas);
      end
    end
    drain();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 160);
    run_random_phase(54, 0, 160);
    run_random_phase(0, 54, 160);
    run_random_phase(14, 14, 150);
  endtask

  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_req      = 1'b1;
    for (int i = 0; i < 12; i++) step(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    drain();
  endtask

  // output side: random stalls, or a long hold on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic signed [DRIVE_W-1:0] exp_drive;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_drive.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got drive %0d", $time, drive);
      end else begin
        exp_drive = expected_drive.pop_front();
        if (drive !== exp_drive) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: drive mismatch, expected %0d, got %0d", $time, exp_drive, drive);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_drive.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = 1'b0;
    target    = '0;
    measured  = '0;
    kp = '0;
    ki = '0;
    kd = '0;
    integ_lim = '0;
    drive_lim = '0;
    band      = '0;
    ratio_q8  = RATIO_W'(RATIO_ONE);
    err_prev  = 0;
    integ_acc = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_random_traffic();
    test_backpressure();

    $display("Checked %0d drive values from %0d requests (%0d clears), %0d register writes,",
             n_results, n_requests, n_clears, n_writes);
    $display("over four idle/stall mixes and a %0d-cycle output hold.", HOLD_LEN);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
